### rtl/cbs_pkg.sv
package cbs_pkg;

	localparam int CANVAS_WIDTH_DEF  = 320;
	localparam int CANVAS_HEIGHT_DEF = 180;

	// unsigned canvas positions up to 2047, and signed clip arithmetic
	localparam int OPER_W  = 11;
	localparam int COORD_W = 12;

	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] BLANK_COLOUR = 8'd15;
	localparam logic [4:0] MAX_BRUSH    = 5'd16;

	localparam logic [7:0]  PAINT_RESET = 8'd4;
	localparam logic [4:0]  BRUSH_RESET = 5'd4;
	localparam logic [15:0] COUNT_SAT   = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAINT_COLOUR = 2'd0,
		REG_BRUSH_WIDTH  = 2'd1
	} cbs_reg_t;

	typedef enum logic [1:0] {
		CMD_STAMP = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cbs_cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLIP,
		ST_FILL,
		ST_CLEAR,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} cbs_state_t;

endpackage

### rtl/canvas_brush_stamp.sv
// Channel   Direction  Handshake             Payload
// cmd       in         cmd_valid/cmd_stall   command, column, row
// res       out        res_valid/res_stall   pixel_value, pixels_written
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One command at a time: a stamp clips its square, then fills it with one canvas write
// per cycle; a clear sweeps all W*H entries; a read fetches one pixel; an unused code
// goes straight to the result.
// Reset: a sweep writes colour 15 to all W*H entries; commands stall until it ends,
// cfg is always taken. cmd_stall is high while a command is in progress; a result
// held by res_stall keeps the sequencer waiting.
module canvas_brush_stamp #(
	parameter int CANVAS_WIDTH  = cbs_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = cbs_pkg::CANVAS_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [1:0]                   command,
	input  logic [8:0]                   column,
	input  logic [7:0]                   row,

	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [7:0]                   pixel_value,
	output logic [15:0]                  pixels_written,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                   cfg_data
);

	localparam int STORE  = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int ADDR_W = $clog2(STORE);
	localparam int OW     = cbs_pkg::OPER_W;
	localparam int CW     = cbs_pkg::COORD_W;
	localparam logic [15:0] CLEAR_COUNT =
		(STORE > 65535) ? cbs_pkg::COUNT_SAT : 16'(STORE);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE - 1);
	localparam logic signed [CW-1:0] W_S = CW'(CANVAS_WIDTH);
	localparam logic signed [CW-1:0] H_S = CW'(CANVAS_HEIGHT);

	cbs_pkg::cbs_state_t state_q, state_nxt;

	// config registers
	logic [7:0] paint_q;
	logic [4:0] brush_q;

	// latched command
	logic [1:0] cmd_q;
	logic [8:0] col_q;
	logic [7:0] row_q;

	// fill loop
	logic [OW-1:0] x_q, y_q, xs_q, xe_q, ye_q;
	logic [15:0]   cnt_q;
	logic [7:0]    pix_q;
	logic [ADDR_W-1:0] clr_q;

	// write stage and read data
	logic              wr_en_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [7:0]        wr_data_s1;
	logic [7:0]        rd_data_q;

	logic [7:0] canvas_mem [STORE];

	// output register
	logic        res_valid_q;
	logic [7:0]  pixel_value_q;
	logic [15:0] pixels_written_q;

	// sequencer outputs
	logic cmd_take, wr_go, wr_blank, rd_go, res_load;

	logic cmd_acc;
	assign cmd_acc = cmd_valid && !cmd_stall;

	// ---------------------------------------------------------------
	// clip arithmetic on the latched centre
	logic [4:0]          side;
	logic signed [CW-1:0] sx, sy, ex, ey, xs, ys, xe, ye;
	logic                 box_empty;

	always_comb begin
		side = (brush_q > cbs_pkg::MAX_BRUSH) ? cbs_pkg::MAX_BRUSH : brush_q;
		sx   = CW'(col_q) - CW'(side >> 1);
		sy   = CW'(row_q) - CW'(side >> 1);
		ex   = sx + CW'(side);
		ey   = sy + CW'(side);
		xs   = (sx < 0) ? '0 : sx;
		ys   = (sy < 0) ? '0 : sy;
		xe   = (ex > W_S) ? W_S : ex;
		ye   = (ey > H_S) ? H_S : ey;
		box_empty = (xe <= xs) || (ye <= ys);
	end

	logic read_in_range;
	assign read_in_range = (OW'(col_q) < OW'(CANVAS_WIDTH))
		&& (OW'(row_q) < OW'(CANVAS_HEIGHT));

	logic fill_row_end, fill_last;
	assign fill_row_end = (x_q + OW'(1)) == xe_q;
	assign fill_last    = fill_row_end && ((y_q + OW'(1)) == ye_q);

	// ---------------------------------------------------------------
	// shared address unit: fill pixel or read pixel
	logic [OW-1:0]     unit_y, unit_x;
	logic [ADDR_W-1:0] unit_addr;

	assign unit_y = (state_q == cbs_pkg::ST_READ) ? OW'(row_q) : y_q;
	assign unit_x = (state_q == cbs_pkg::ST_READ) ? OW'(col_q) : x_q;

	cbs_addr_unit #(
		.CANVAS_WIDTH (CANVAS_WIDTH),
		.CANVAS_HEIGHT(CANVAS_HEIGHT)
	) u_addr (
		.y   (unit_y),
		.x   (unit_x),
		.addr(unit_addr)
	);

	// ---------------------------------------------------------------
	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cbs_pkg::ST_INIT: begin
				if (clr_q == LAST_ADDR) state_nxt = cbs_pkg::ST_IDLE;
			end
			cbs_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					case (command)
						cbs_pkg::CMD_STAMP: state_nxt = cbs_pkg::ST_CLIP;
						cbs_pkg::CMD_CLEAR: state_nxt = cbs_pkg::ST_CLEAR;
						cbs_pkg::CMD_READ:  state_nxt = cbs_pkg::ST_READ;
						default:            state_nxt = cbs_pkg::ST_DONE;
					endcase
				end
			end
			cbs_pkg::ST_CLIP: begin
				state_nxt = box_empty ? cbs_pkg::ST_DONE : cbs_pkg::ST_FILL;
			end
			cbs_pkg::ST_FILL: begin
				if (fill_last) state_nxt = cbs_pkg::ST_DONE;
			end
			cbs_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_nxt = cbs_pkg::ST_DONE;
			end
			cbs_pkg::ST_READ:      state_nxt = cbs_pkg::ST_READ_WAIT;
			cbs_pkg::ST_READ_WAIT: state_nxt = cbs_pkg::ST_DONE;
			cbs_pkg::ST_DONE: begin
				if (res_load) state_nxt = cbs_pkg::ST_IDLE;
			end
			default: state_nxt = cbs_pkg::ST_INIT;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_stall = 1'b1;
		cmd_take  = 1'b0;
		wr_go     = 1'b0;
		wr_blank  = 1'b0;
		rd_go     = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			cbs_pkg::ST_INIT: begin
				wr_go    = 1'b1;
				wr_blank = 1'b1;
			end
			cbs_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				cmd_take  = cmd_valid;
			end
			cbs_pkg::ST_FILL:  wr_go = 1'b1;
			cbs_pkg::ST_CLEAR: begin
				wr_go    = 1'b1;
				wr_blank = 1'b1;
			end
			cbs_pkg::ST_READ: rd_go = read_in_range;
			cbs_pkg::ST_DONE: res_load = !res_valid_q || !res_stall;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbs_pkg::ST_INIT;
			paint_q     <= cbs_pkg::PAINT_RESET;
			brush_q     <= cbs_pkg::BRUSH_RESET;
			clr_q       <= '0;
			wr_en_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			wr_en_s1 <= wr_go;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cbs_pkg::REG_PAINT_COLOUR: paint_q <= cfg_data;
					cbs_pkg::REG_BRUSH_WIDTH:  brush_q <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (cmd_take) clr_q <= '0;
			else if (wr_blank) clr_q <= clr_q + ADDR_W'(1);

			if (res_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	assign cfg_ready = 1'b1;

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= command;
			col_q <= column;
			row_q <= row;
			cnt_q <= '0;
			pix_q <= '0;
		end

		case (state_q)
			cbs_pkg::ST_CLIP: begin
				xs_q <= xs[OW-1:0];
				xe_q <= xe[OW-1:0];
				ye_q <= ye[OW-1:0];
				x_q  <= xs[OW-1:0];
				y_q  <= ys[OW-1:0];
			end
			cbs_pkg::ST_FILL: begin
				cnt_q <= cnt_q + 16'd1;
				if (fill_row_end) begin
					x_q <= xs_q;
					y_q <= y_q + OW'(1);
				end else begin
					x_q <= x_q + OW'(1);
				end
			end
			cbs_pkg::ST_CLEAR: cnt_q <= CLEAR_COUNT;
			cbs_pkg::ST_READ_WAIT: pix_q <= read_in_range ? rd_data_q : 8'd0;
			default: ;
		endcase

		wr_addr_s1 <= wr_blank ? clr_q : unit_addr;
		wr_data_s1 <= wr_blank ? cbs_pkg::BLANK_COLOUR : paint_q;

		if (res_load) begin
			pixel_value_q    <= (cmd_q == cbs_pkg::CMD_READ) ? pix_q : 8'd0;
			pixels_written_q <= cnt_q;
		end
	end

	// canvas store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en_s1) canvas_mem[wr_addr_s1] <= wr_data_s1;
		if (rd_go) rd_data_q <= canvas_mem[unit_addr];
	end

	assign res_valid      = res_valid_q;
	assign pixel_value    = pixel_value_q;
	assign pixels_written = pixels_written_q;

endmodule

### rtl/cbs_addr_unit.sv
// Shared address unit: addr = y * CANVAS_WIDTH + x
module cbs_addr_unit #(
	parameter int CANVAS_WIDTH  = cbs_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = cbs_pkg::CANVAS_HEIGHT_DEF,
	localparam int ADDR_W = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT)
) (
	input  logic [cbs_pkg::OPER_W-1:0] y,
	input  logic [cbs_pkg::OPER_W-1:0] x,
	output logic [ADDR_W-1:0]          addr
);

	localparam int FULL_W = 2 * cbs_pkg::OPER_W + 1;

	logic [FULL_W-1:0] full;

	assign full = FULL_W'(y) * FULL_W'(CANVAS_WIDTH) + FULL_W'(x);
	assign addr = full[ADDR_W-1:0];

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for canvas_brush_stamp.
// A local canvas model tracks every pixel. Each accepted command runs through it,
// and its result, or a typed expected result, is queued. Each result transaction from the DUT is checked
// against the head of that queue.
// Register writes happen only while nothing is in flight.
module tb;

	localparam int NUM_COLS = cbs_pkg::CANVAS_WIDTH_DEF;
	localparam int NUM_ROWS = cbs_pkg::CANVAS_HEIGHT_DEF;
	localparam int PIXELS   = NUM_COLS * NUM_ROWS;

	// cfg indexes past the register list: the DUT must drop these writes
	localparam logic [cbs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [cbs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int RANDOM_ITEMS = 1730;
	localparam int LONG_HOLD    = 500;
	localparam int TAIL_CYCLES  = 16;
	// Worst case: the reset sweep, plus one directed clear and up to three random
	// clears, plus about 1750 items.
	// The limit stays well above that total.
	localparam int LIMIT_CYCLES = 5_000_000;

	typedef struct packed {
		logic [7:0]  pix;
		logic [15:0] cnt;
	} result_t;

	typedef struct packed {
		bit                            is_reg;
		logic [cbs_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [7:0]                    reg_data;
		cbs_pkg::cbs_cmd_t             cmd;
		logic [8:0]                    x;
		logic [7:0]                    y;
		bit                            typed;
		result_t                       want;
	} step_t;

	// Directed sequence. Rows with typed=1 carry the expected result directly.
	// The other rows are checked against the canvas model.
	localparam int NUM_DIRECTED = 31;
	localparam step_t DIRECTED [NUM_DIRECTED] = '{
		// fresh canvas: blank everywhere, including both corners
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd0,   8'd0,   1'b1, '{8'd15, 16'd0}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd319, 8'd179, 1'b1, '{8'd15, 16'd0}},
		// reads off the canvas give 0
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd320, 8'd0,   1'b1, '{8'd0, 16'd0}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd511, 8'd255, 1'b1, '{8'd0, 16'd0}},
		// unused opcode
		'{1'b0, '0, '0, cbs_pkg::CMD_NOP,   9'd511, 8'd255, 1'b1, '{8'd0, 16'd0}},
		// default brush 4, colour 4: a corner stamp is clipped to 2x2
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd0,   8'd0,   1'b1, '{8'd0, 16'd4}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd0,   8'd0,   1'b1, '{8'd4, 16'd0}},
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd160, 8'd90,  1'b1, '{8'd0, 16'd16}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd161, 8'd91,  1'b0, '0},
		'{1'b1, cbs_pkg::REG_PAINT_COLOUR, 8'hFF, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b1, cbs_pkg::REG_BRUSH_WIDTH,  8'd16, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		// full 16x16 brush, then the far corner clipped to 9x9
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd100, 8'd100, 1'b1, '{8'd0, 16'd256}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd107, 8'd107, 1'b1, '{8'hFF, 16'd0}},
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd319, 8'd179, 1'b1, '{8'd0, 16'd81}},
		// clipped to nothing
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd511, 8'd255, 1'b1, '{8'd0, 16'd0}},
		// zero width writes nothing
		'{1'b1, cbs_pkg::REG_BRUSH_WIDTH,  8'd0, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd50,  8'd50,  1'b1, '{8'd0, 16'd0}},
		// width 31 is treated as 16. Bits above the field are dropped.
		'{1'b1, cbs_pkg::REG_BRUSH_WIDTH,  8'hFF, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b1, cbs_pkg::REG_PAINT_COLOUR, 8'h00, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd200, 8'd50,  1'b1, '{8'd0, 16'd256}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd200, 8'd50,  1'b1, '{8'd0, 16'd0}},
		// data 0xE1 gives width 1
		'{1'b1, cbs_pkg::REG_BRUSH_WIDTH,  8'hE1, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b1, cbs_pkg::REG_PAINT_COLOUR, 8'hA5, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		// spare indexes must not touch either register
		'{1'b1, REG_SPARE_A,      8'h5A, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b1, REG_SPARE_B,      8'hC3, cbs_pkg::CMD_NOP, '0, '0, 1'b0, '0},
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd0,   8'd179, 1'b1, '{8'd0, 16'd1}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd0,   8'd179, 1'b1, '{8'hA5, 16'd0}},
		'{1'b0, '0, '0, cbs_pkg::CMD_STAMP, 9'd319, 8'd0,   1'b0, '0},
		// full clear, then back to blank
		'{1'b0, '0, '0, cbs_pkg::CMD_CLEAR, 9'd0,   8'd0,   1'b1, '{8'd0, 16'd57600}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd100, 8'd100, 1'b1, '{8'd15, 16'd0}},
		'{1'b0, '0, '0, cbs_pkg::CMD_READ,  9'd319, 8'd0,   1'b0, '0}
	};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cmd_valid = 1'b0;
	logic                          cmd_stall;
	logic [1:0]                    command   = '0;
	logic [8:0]                    column    = '0;
	logic [7:0]                    row       = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [7:0]                    pixel_value;
	logic [15:0]                   pixels_written;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_data  = '0;

	// canvas model and its register copies
	logic [7:0] canvas_img [PIXELS];
	logic [7:0] paint_reg;
	logic [4:0] brush_reg;

	result_t pending_results [$];
	int      errors      = 0;
	int      cycle_count = 0;
	bit      quiet       = 1'b0;	// phase with no idling on either side

	canvas_brush_stamp #(
		.CANVAS_WIDTH  (NUM_COLS),
		.CANVAS_HEIGHT (NUM_ROWS)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.command        (command),
		.column         (column),
		.row            (row),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.pixel_value    (pixel_value),
		.pixels_written (pixels_written),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one command to the canvas model and return the result it should give.
	function automatic result_t apply_command(cbs_pkg::cbs_cmd_t c, logic [8:0] px,
			logic [7:0] py);
		result_t     r;
		int          side, half, x0, y0, x1, y1;
		int unsigned n;
		r = '0;
		case (c)
			cbs_pkg::CMD_STAMP: begin
				side = (brush_reg > cbs_pkg::MAX_BRUSH) ? cbs_pkg::MAX_BRUSH : brush_reg;
				half = side / 2;
				x0 = int'(px) - half;
				y0 = int'(py) - half;
				x1 = x0 + side;
				y1 = y0 + side;
				if (x0 < 0) x0 = 0;
				if (y0 < 0) y0 = 0;
				if (x1 > NUM_COLS) x1 = NUM_COLS;
				if (y1 > NUM_ROWS) y1 = NUM_ROWS;
				n = 0;
				for (int yy = y0; yy < y1; yy++) begin
					for (int xx = x0; xx < x1; xx++) begin
						canvas_img[yy * NUM_COLS + xx] = paint_reg;
						n++;
					end
				end
				r.cnt = n[15:0];
			end
			cbs_pkg::CMD_CLEAR: begin
				foreach (canvas_img[i]) canvas_img[i] = cbs_pkg::BLANK_COLOUR;
				r.cnt = (PIXELS > 65535) ? cbs_pkg::COUNT_SAT : 16'(PIXELS);
			end
			cbs_pkg::CMD_READ: begin
				if (px < NUM_COLS && py < NUM_ROWS)
					r.pix = canvas_img[int'(py) * NUM_COLS + int'(px)];
			end
			default: ;
		endcase
		return r;
	endfunction

	// Drop both valids, then wait until every queued result has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// cfg transaction. valid is left high so back-to-back writes stream.
	task automatic write_reg(logic [cbs_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			cbs_pkg::REG_PAINT_COLOUR: paint_reg = data;
			cbs_pkg::REG_BRUSH_WIDTH:  brush_reg = data[4:0];
			default: ;
		endcase
	endtask

	// cmd transaction. It queues the typed result if given, or else the model's.
	// valid stays high after acceptance so a zero gap keeps it up.
	task automatic send_cmd(cbs_pkg::cbs_cmd_t c, logic [8:0] px, logic [7:0] py,
			bit typed, result_t want);
		int      gap;
		result_t predicted;
		gap = quiet ? 0 : $urandom_range(0, 4);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= c;
		column    <= px;
		row       <= py;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		predicted = apply_command(c, px, py);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Mostly on-canvas points. Some span the full field width, so every port bit toggles.
	task automatic draw_point(output logic [8:0] px, output logic [7:0] py);
		if ($urandom_range(0, 99) < 85) begin
			px = 9'($urandom_range(0, NUM_COLS - 1));
			py = 8'($urandom_range(0, NUM_ROWS - 1));
		end else begin
			px = 9'($urandom_range(0, 511));
			py = 8'($urandom_range(0, 255));
		end
	endtask

	// stimulus
	initial begin : cmd_side
		int         sent, batch, pick, clears_left, last_x, last_y, tx, ty;
		logic [8:0] px;
		logic [7:0] py;
		logic [4:0] bw;

		paint_reg = cbs_pkg::PAINT_RESET;
		brush_reg = cbs_pkg::BRUSH_RESET;
		void'(apply_command(cbs_pkg::CMD_CLEAR, '0, '0));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_reg) begin
				wait_drained();
				write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
			end else begin
				send_cmd(DIRECTED[i].cmd, DIRECTED[i].x, DIRECTED[i].y,
					DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		// Random phases. Each phase drains, reprograms the registers, then sends a batch.
		sent        = 0;
		clears_left = 3;
		last_x      = 160;
		last_y      = 90;
		while (sent < RANDOM_ITEMS) begin
			wait_drained();
			write_reg(cbs_pkg::REG_PAINT_COLOUR, 8'($urandom));
			case ($urandom_range(0, 9))
				0:       bw = 5'd0;
				1:       bw = 5'($urandom_range(17, 31));
				default: bw = 5'($urandom_range(1, 16));
			endcase
			write_reg(cbs_pkg::REG_BRUSH_WIDTH, {3'($urandom), bw});
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));

			quiet = ($urandom_range(0, 3) == 0);
			batch = $urandom_range(15, 60);
			for (int k = 0; k < batch && sent < RANDOM_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (clears_left > 0 && $urandom_range(0, 399) == 0) begin
					clears_left--;
					send_cmd(cbs_pkg::CMD_CLEAR, 9'($urandom), 8'($urandom), 1'b0, '0);
					sent++;
				end else if (pick < 50) begin
					draw_point(px, py);
					last_x = int'(px);
					last_y = int'(py);
					send_cmd(cbs_pkg::CMD_STAMP, px, py, 1'b0, '0);
					sent++;
				end else if (pick < 94) begin
					// Most reads land around the last stamp, so they see painted pixels.
					if ($urandom_range(0, 99) < 60) begin
						tx = last_x + $urandom_range(0, 20) - 10;
						ty = last_y + $urandom_range(0, 20) - 10;
						px = (tx < 0) ? 9'd0 : 9'(tx);
						py = (ty < 0) ? 8'd0 : 8'(ty);
					end else begin
						draw_point(px, py);
					end
					send_cmd(cbs_pkg::CMD_READ, px, py, 1'b0, '0);
					sent++;
				end else begin
					send_cmd(cbs_pkg::CMD_NOP, 9'($urandom), 8'($urandom), 1'b0, '0);
					sent++;
				end
			end
		end

		wait_drained();
		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Receiver stall. After each result transaction, draw a random hold length. Its
	// cycles count only while res_valid is up, so the stall overlaps a real result.
	// Twice in the run, hold res_stall high while the sender is offering.
	// The DUT then backs up into cmd_stall.
	initial begin : result_side
		int hold;
		int taken;
		int next_long;
		taken     = 0;
		next_long = 200;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				taken++;
				if (taken >= next_long && next_long < 2000 && cmd_valid) begin
					res_stall <= 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
					res_stall <= 1'b0;
					next_long += 1000;
				end else begin
					hold = quiet ? 0 : $urandom_range(0, 4);
					if (hold > 0) begin
						res_stall <= 1'b1;
						while (hold > 0) begin
							@(posedge clk);
							if (res_valid) hold--;
						end
						res_stall <= 1'b0;
					end
				end
			end
		end
	end

	// Scoreboard: each result transaction against the oldest queued result.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: pixel_value %0d pixels_written %0d",
					pixel_value, pixels_written);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (pixel_value !== want.pix) begin
					$error("pixel_value expected %0d actual %0d", want.pix, pixel_value);
					errors++;
				end
				if (pixels_written !== want.cnt) begin
					$error("pixels_written expected %0d actual %0d",
						want.cnt, pixels_written);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
